FILE: hdl/dpsc_pkg.sv
package dpsc_pkg;

    localparam int unsigned DcountWidth  = 18;
    localparam int unsigned StimWidth    = 20;
    localparam int unsigned IgnoreWidth  = 16;
    localparam int unsigned PercentWidth = 7;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 20;

    localparam logic [DcountWidth-1:0]  DisconnectTimeoutReset = 18'd180000;
    localparam logic [DcountWidth-1:0]  DisconnectStartReset   = 18'd1000;
    localparam logic [IgnoreWidth-1:0]  ButtonIgnoreReset      = 16'd300;
    localparam logic [StimWidth-1:0]    LowStimPeriodReset     = 20'd600000;
    localparam logic [PercentWidth-1:0] PowerOffPercentReset   = 7'd40;
    localparam logic [PercentWidth-1:0] LowStimPercentReset    = 7'd20;

    localparam int unsigned FlagRadio   = 0;
    localparam int unsigned FlagPmic    = 1;
    localparam int unsigned FlagImplant = 2;
    localparam int unsigned FlagShut    = 3;
    localparam int unsigned FlagLid     = 4;
    localparam int unsigned FlagCount   = 5;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_DISCONNECT_TIMEOUT = 3'd0,
        CFG_DISCONNECT_START   = 3'd1,
        CFG_BUTTON_IGNORE      = 3'd2,
        CFG_LOW_STIM_PERIOD    = 3'd3,
        CFG_POWER_OFF_PERCENT  = 3'd4,
        CFG_LOW_STIM_PERCENT   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        PLUG_UNKNOWN      = 2'd0,
        PLUG_CONNECTED    = 2'd1,
        PLUG_DISCONNECTED = 2'd2
    } plug_state_t;

    typedef enum logic [2:0] {
        ERR_LED_NONE    = 3'd0,
        ERR_LED_CLEAR   = 3'd1,
        ERR_LED_GENERIC = 3'd2,
        ERR_LED_MAP     = 3'd3,
        ERR_LED_ACCEL   = 3'd4,
        ERR_LED_FPGA    = 3'd5
    } err_led_t;

    typedef struct packed {
        logic                    err_data_processing;
        logic                    err_accelerometer;
        logic                    err_fpga_link;
        logic                    err_logging;
        logic [1:0]              charger_state;
        logic [1:0]              case_state;
        logic                    cover_open;
        logic [PercentWidth-1:0] battery_level;
        logic                    button_pressed;
        logic                    link_up;
        logic                    mapping_active;
        logic                    led_busy;
    } tick_t;

    typedef struct packed {
        logic [FlagCount-1:0] flags;
        logic                 stim_trigger;
        logic                 power_off_led;
        err_led_t             error_led;
        logic                 audio_mute;
    } result_t;

endpackage

FILE: hdl/dpsc_if.sv
interface dpsc_tick_if;
    logic       valid;
    logic       ready;
    logic       err_data_processing;
    logic       err_accelerometer;
    logic       err_fpga_link;
    logic       err_logging;
    logic [1:0] charger_state;
    logic [1:0] case_state;
    logic       cover_open;
    logic [6:0] battery_level;
    logic       button_pressed;
    logic       link_up;
    logic       mapping_active;
    logic       led_busy;

    modport source (
        output valid, err_data_processing, err_accelerometer, err_fpga_link, err_logging,
               charger_state, case_state, cover_open, battery_level, button_pressed,
               link_up, mapping_active, led_busy,
        input  ready
    );

    modport sink (
        input  valid, err_data_processing, err_accelerometer, err_fpga_link, err_logging,
               charger_state, case_state, cover_open, battery_level, button_pressed,
               link_up, mapping_active, led_busy,
        output ready
    );
endinterface

interface dpsc_status_if;
    logic       valid;
    logic       ready;
    logic       radio_off;
    logic       pmic_enable;
    logic       implant_enable;
    logic       system_shutdown;
    logic       lid_closed_seen;
    logic       stim_trigger;
    logic       power_off_led;
    logic [2:0] error_led;
    logic       audio_mute;

    modport source (
        output valid, radio_off, pmic_enable, implant_enable, system_shutdown,
               lid_closed_seen, stim_trigger, power_off_led, error_led, audio_mute,
        input  ready
    );

    modport sink (
        input  valid, radio_off, pmic_enable, implant_enable, system_shutdown,
               lid_closed_seen, stim_trigger, power_off_led, error_led, audio_mute,
        output ready
    );
endinterface

FILE: hdl/device_power_state_controller.sv
// Device power state controller. One tick beat per millisecond carries error flags,
// charger/case/lid state, battery percent, button, link, mapping and LED-busy flags;
// each tick beat yields exactly one status beat with the power flags (shutdown and
// lid-closed sticky), the stimulation and power-off LED pulses, the error LED code
// and the audio mute pulse. A tick beat is registered, evaluated combinationally
// against the controller state and the status beat lands in an output register;
// one tick beat is taken every cycle while the status side keeps up. Configuration
// writes must happen while no tick is in flight; they affect the evaluation of later
// ticks, but writes to the disconnect counter start are ignored; it resets to its default.
module device_power_state_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dpsc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [dpsc_pkg::CfgDataWidth-1:0]   cfg_wdata,
    dpsc_tick_if.sink                           tick,
    dpsc_status_if.source                       status
);

    // configuration
    logic [dpsc_pkg::DcountWidth-1:0]  timeout_reg;
    logic [dpsc_pkg::IgnoreWidth-1:0]  ignore_reg;
    logic [dpsc_pkg::StimWidth-1:0]    period_reg;
    logic [dpsc_pkg::PercentWidth-1:0] off_pct_reg;
    logic [dpsc_pkg::PercentWidth-1:0] stim_pct_reg;

    // controller state
    logic                              started_reg, started_next;
    logic                              off_pending_reg, off_pending_next;
    logic                              off_ticked_reg, off_ticked_next;
    logic [dpsc_pkg::DcountWidth-1:0]  dcount_reg, dcount_next;
    logic [dpsc_pkg::StimWidth-1:0]    stim_cnt_reg, stim_cnt_next;
    logic                              lid_edge_reg, lid_edge_next;
    logic [1:0]                        prev_case_reg, prev_case_next;
    logic [dpsc_pkg::FlagCount-1:0]    flags_reg, flags_next;

    // pipeline
    logic               in_valid_reg;
    dpsc_pkg::tick_t    in_reg;
    logic               out_valid_reg;
    dpsc_pkg::result_t  out_reg;
    dpsc_pkg::result_t  result;
    logic               out_free;
    logic               eval_fire;
    logic               tick_fire;

    // evaluation temporaries
    logic                               any_err;
    logic                               button_eff;
    logic                               low_batt;
    logic [dpsc_pkg::DcountWidth:0]     dcount_inc;
    logic [dpsc_pkg::StimWidth-1:0]     stim_base;

    assign out_free  = !out_valid_reg || status.ready;
    assign eval_fire = in_valid_reg && out_free;
    assign tick.ready = !in_valid_reg || out_free;
    assign tick_fire = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= dpsc_pkg::DisconnectTimeoutReset;
            ignore_reg   <= dpsc_pkg::ButtonIgnoreReset;
            period_reg   <= dpsc_pkg::LowStimPeriodReset;
            off_pct_reg  <= dpsc_pkg::PowerOffPercentReset;
            stim_pct_reg <= dpsc_pkg::LowStimPercentReset;
        end
        else if (cfg_wr_en)
        begin
            case (dpsc_pkg::cfg_index_t'(cfg_index))
                dpsc_pkg::CFG_DISCONNECT_TIMEOUT:
                    timeout_reg <= cfg_wdata[dpsc_pkg::DcountWidth-1:0];
                dpsc_pkg::CFG_BUTTON_IGNORE:
                    ignore_reg <= cfg_wdata[dpsc_pkg::IgnoreWidth-1:0];
                dpsc_pkg::CFG_LOW_STIM_PERIOD:
                    period_reg <= cfg_wdata[dpsc_pkg::StimWidth-1:0];
                dpsc_pkg::CFG_POWER_OFF_PERCENT:
                    off_pct_reg <= cfg_wdata[dpsc_pkg::PercentWidth-1:0];
                dpsc_pkg::CFG_LOW_STIM_PERCENT:
                    stim_pct_reg <= cfg_wdata[dpsc_pkg::PercentWidth-1:0];
                // counter start only matters at reset, which restores its default
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        started_next     = started_reg;
        off_pending_next = off_pending_reg;
        off_ticked_next  = off_ticked_reg;
        dcount_next      = dcount_reg;
        stim_cnt_next    = stim_cnt_reg;
        lid_edge_next    = lid_edge_reg;
        prev_case_next   = prev_case_reg;
        flags_next       = flags_reg;

        result.stim_trigger  = 1'b0;
        result.power_off_led = 1'b0;
        result.audio_mute    = 1'b0;
        result.error_led     = dpsc_pkg::ERR_LED_CLEAR;

        any_err = in_reg.err_data_processing || in_reg.err_accelerometer
               || in_reg.err_fpga_link || in_reg.err_logging;
        button_eff = in_reg.button_pressed && !in_reg.mapping_active
                  && !(dcount_reg < {2'b00, ignore_reg});
        low_batt   = in_reg.battery_level < off_pct_reg;
        dcount_inc = in_reg.link_up ? '0 : {1'b0, dcount_reg} + 1'b1;
        stim_base  = (stim_cnt_reg == '0) ? period_reg : stim_cnt_reg;

        if (any_err)
        begin
            result.error_led = dpsc_pkg::ERR_LED_GENERIC;
            if (in_reg.err_data_processing)
                result.error_led = dpsc_pkg::ERR_LED_MAP;
            if (in_reg.err_accelerometer)
                result.error_led = dpsc_pkg::ERR_LED_ACCEL;
            if (in_reg.err_fpga_link)
                result.error_led = dpsc_pkg::ERR_LED_FPGA;
        end
        else
        begin
            case (dpsc_pkg::plug_state_t'(in_reg.charger_state))
                dpsc_pkg::PLUG_CONNECTED:
                begin
                    flags_next[dpsc_pkg::FlagRadio] = 1'b1;
                    flags_next[dpsc_pkg::FlagPmic]  = 1'b0;
                    result.audio_mute = 1'b1;
                    if (in_reg.case_state == dpsc_pkg::PLUG_CONNECTED)
                    begin
                        if (in_reg.cover_open)
                            lid_edge_next = 1'b0;
                        else if (!lid_edge_reg)
                        begin
                            lid_edge_next = 1'b1;
                            flags_next[dpsc_pkg::FlagLid] = 1'b1;
                        end
                    end
                    started_next = 1'b0;
                end
                dpsc_pkg::PLUG_DISCONNECTED:
                begin
                    flags_next[dpsc_pkg::FlagRadio] = 1'b0;
                    if (prev_case_reg == in_reg.case_state)
                    begin
                        if (!started_reg)
                            started_next = 1'b1;
                        else if (!in_reg.led_busy)
                        begin
                            flags_next[dpsc_pkg::FlagImplant] = 1'b1;
                            flags_next[dpsc_pkg::FlagPmic]    = 1'b1;
                            if ((low_batt || button_eff) && !off_pending_reg)
                            begin
                                result.power_off_led = 1'b1;
                                flags_next[dpsc_pkg::FlagImplant] = 1'b0;
                                off_ticked_next  = 1'b0;
                                off_pending_next = 1'b1;
                            end
                            if (off_pending_next)
                            begin
                                if (off_ticked_next)
                                begin
                                    off_pending_next = 1'b0;
                                    dcount_next      = '0;
                                    flags_next[dpsc_pkg::FlagPmic] = 1'b0;
                                    flags_next[dpsc_pkg::FlagShut] = 1'b1;
                                end
                                else if (!low_batt && in_reg.link_up)
                                    off_pending_next = 1'b0;
                                off_ticked_next = 1'b1;
                            end
                            else
                            begin
                                if (in_reg.link_up && (in_reg.battery_level < stim_pct_reg))
                                begin
                                    result.stim_trigger = (stim_cnt_reg == '0);
                                    stim_cnt_next = stim_base - 1'b1;
                                end
                                else
                                    stim_cnt_next = '0;
                                if (dcount_inc > {1'b0, timeout_reg})
                                begin
                                    dcount_next = '0;
                                    result.power_off_led = 1'b1;
                                    flags_next[dpsc_pkg::FlagImplant] = 1'b0;
                                    off_ticked_next  = 1'b0;
                                    off_pending_next = 1'b1;
                                end
                                else if (dcount_inc[dpsc_pkg::DcountWidth])
                                    dcount_next = '1;
                                else
                                    dcount_next = dcount_inc[dpsc_pkg::DcountWidth-1:0];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            prev_case_next = in_reg.case_state;
        end

        result.flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            started_reg     <= 1'b0;
            off_pending_reg <= 1'b0;
            off_ticked_reg  <= 1'b0;
            dcount_reg      <= dpsc_pkg::DisconnectStartReset;
            stim_cnt_reg    <= '0;
            lid_edge_reg    <= 1'b0;
            prev_case_reg   <= dpsc_pkg::PLUG_UNKNOWN;
            flags_reg       <= '0;
        end
        else
        begin
            if (tick_fire)
                in_valid_reg <= 1'b1;
            else if (eval_fire)
                in_valid_reg <= 1'b0;

            if (eval_fire)
                out_valid_reg <= 1'b1;
            else if (status.ready)
                out_valid_reg <= 1'b0;

            if (eval_fire)
            begin
                started_reg     <= started_next;
                off_pending_reg <= off_pending_next;
                off_ticked_reg  <= off_ticked_next;
                dcount_reg      <= dcount_next;
                stim_cnt_reg    <= stim_cnt_next;
                lid_edge_reg    <= lid_edge_next;
                prev_case_reg   <= prev_case_next;
                flags_reg       <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            in_reg.err_data_processing <= tick.err_data_processing;
            in_reg.err_accelerometer   <= tick.err_accelerometer;
            in_reg.err_fpga_link       <= tick.err_fpga_link;
            in_reg.err_logging         <= tick.err_logging;
            in_reg.charger_state       <= tick.charger_state;
            in_reg.case_state          <= tick.case_state;
            in_reg.cover_open          <= tick.cover_open;
            in_reg.battery_level       <= tick.battery_level;
            in_reg.button_pressed      <= tick.button_pressed;
            in_reg.link_up             <= tick.link_up;
            in_reg.mapping_active      <= tick.mapping_active;
            in_reg.led_busy            <= tick.led_busy;
        end
        if (eval_fire)
            out_reg <= result;
    end

    assign status.valid           = out_valid_reg;
    assign status.radio_off       = out_reg.flags[dpsc_pkg::FlagRadio];
    assign status.pmic_enable     = out_reg.flags[dpsc_pkg::FlagPmic];
    assign status.implant_enable  = out_reg.flags[dpsc_pkg::FlagImplant];
    assign status.system_shutdown = out_reg.flags[dpsc_pkg::FlagShut];
    assign status.lid_closed_seen = out_reg.flags[dpsc_pkg::FlagLid];
    assign status.stim_trigger    = out_reg.stim_trigger;
    assign status.power_off_led   = out_reg.power_off_led;
    assign status.error_led       = out_reg.error_led;
    assign status.audio_mute      = out_reg.audio_mute;

`ifndef SYNTHESIS
    a_shut_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[dpsc_pkg::FlagShut] |=> flags_reg[dpsc_pkg::FlagShut])
        else $error("shutdown flag dropped");

    a_lid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[dpsc_pkg::FlagLid] |=> flags_reg[dpsc_pkg::FlagLid])
        else $error("lid flag dropped");

    a_pulse_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.stim_trigger || out_reg.audio_mute
                          || out_reg.power_off_led)
        |-> out_reg.error_led == dpsc_pkg::ERR_LED_CLEAR)
        else $error("pulse on error beat");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !status.ready |-> !tick.ready)
        else $error("tick taken while pipeline full");
`endif

endmodule
